@@ sv/kmeans_2d_cluster_macros.svh @@
// kmeans_2d_cluster_macros.svh: assertion macros for the k-means block
// used by the port checker; no other dependencies
`ifndef KMEANS_2D_CLUSTER_MACROS_SVH
`define KMEANS_2D_CLUSTER_MACROS_SVH

// antecedent in this cycle implies consequent in the next
`define KM_ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define KM_ASSERT_NOW(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

`endif

@@ sv/km2d_pkg.sv @@
// km2d_pkg: shared constants and command codes of the k-means block
// no dependencies
`timescale 1ns / 1ps
package km2d_pkg;
  localparam int DEF_MAX_POINTS   = 1024;
  localparam int DEF_MAX_CLUSTERS = 16;
  localparam int DEF_COORD_BITS   = 10;
  localparam int FIELD_W = 10;
  localparam int LABEL_W = 4;
  localparam logic [1:0] CMD_LOAD_POINT  = 2'd0;
  localparam logic [1:0] CMD_LOAD_CENTER = 2'd1;
  localparam logic [1:0] CMD_RUN         = 2'd2;
  localparam logic [1:0] CMD_READ        = 2'd3;
  localparam logic REG_NUM_CLUSTERS = 1'b0;
  localparam logic REG_MAX_PASSES   = 1'b1;
endpackage

@@ sv/km2d_point_mem.sv @@
// km2d_point_mem: point coordinate and label memories, read data registered
// uses km2d_pkg
`timescale 1ns / 1ps
module km2d_point_mem import km2d_pkg::*; #(
  parameter int MAX_POINTS   = DEF_MAX_POINTS,
  parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
  parameter int COORD_BITS   = DEF_COORD_BITS
) (
  input  logic                            clk,
  input  logic                            xy_we,
  input  logic [$clog2(MAX_POINTS)-1:0]   xy_addr,
  input  logic [COORD_BITS-1:0]           xy_x,
  input  logic [COORD_BITS-1:0]           xy_y,
  input  logic                            lb_we,
  input  logic [$clog2(MAX_POINTS)-1:0]   lb_addr,
  input  logic [$clog2(MAX_CLUSTERS)-1:0] lb_data,
  input  logic [$clog2(MAX_POINTS)-1:0]   rd_addr,
  output logic [COORD_BITS-1:0]           rd_x,
  output logic [COORD_BITS-1:0]           rd_y,
  output logic [$clog2(MAX_CLUSTERS)-1:0] rd_lb
);
  logic [2*COORD_BITS-1:0]           xy_mem [MAX_POINTS];
  logic [$clog2(MAX_CLUSTERS)-1:0]   lb_mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (xy_we) xy_mem[xy_addr] <= {xy_x, xy_y};
    {rd_x, rd_y} <= xy_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (lb_we) lb_mem[lb_addr] <= lb_data;
    rd_lb <= lb_mem[rd_addr];
  end
endmodule

@@ sv/km2d_divider.sv @@
// km2d_divider: restoring divider, one quotient bit per cycle
// uses km2d_pkg
`timescale 1ns / 1ps
module km2d_divider import km2d_pkg::*; #(
  parameter int NUM_W = 2 * DEF_COORD_BITS,
  parameter int DEN_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);
  localparam int CNT_W = $clog2(NUM_W + 1);
  logic             active;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_next;
  logic             bit_next;

  always_comb begin
    rem_sh = {rem[DEN_W-1:0], quotient[NUM_W-1]};
    if (rem_sh >= {1'b0, den}) begin
      rem_next = rem_sh - {1'b0, den};
      bit_next = 1'b1;
    end else begin
      rem_next = rem_sh;
      bit_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start && !active) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !active) begin
      rem      <= '0;
      den      <= divisor;
      quotient <= dividend;
    end else if (active) begin
      rem      <= rem_next;
      quotient <= {quotient[NUM_W-2:0], bit_next};
    end
  end
endmodule

@@ sv/kmeans_2d_cluster.sv @@
// kmeans_2d_cluster: 2-D Lloyd k-means sequencer around the point memory
// uses km2d_pkg, km2d_point_mem, km2d_divider
`timescale 1ns / 1ps
//  channel   ports                                         beat
//  command   start busy cmd x_coord y_coord item_index     start && !busy
//  result    done cluster_index center_x center_y label    done, one cycle
//            passes_done converged last
//  config    cfg_we cfg_index cfg_data                     cfg_we
//
//  a load does not make the block busy; a label read answers in the next cycle.
//  a run labels every point in each pass (one center per cycle, point memory
//  read first), refills each empty cluster from the largest one, and sends the sums
//  of each nonempty cluster through the serial divider; then one result beat per cluster.
//  reset is synchronous; the result side cannot stall, busy holds off commands.
module kmeans_2d_cluster import km2d_pkg::*; #(
  parameter int MAX_POINTS   = DEF_MAX_POINTS,
  parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
  parameter int COORD_BITS   = DEF_COORD_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd,
  input  logic [FIELD_W-1:0] x_coord,
  input  logic [FIELD_W-1:0] y_coord,
  input  logic [FIELD_W-1:0] item_index,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [FIELD_W-1:0] cfg_data,
  output logic               done,
  output logic [LABEL_W-1:0] cluster_index,
  output logic [FIELD_W-1:0] center_x,
  output logic [FIELD_W-1:0] center_y,
  output logic [LABEL_W-1:0] label,
  output logic [FIELD_W-1:0] passes_done,
  output logic               converged,
  output logic               last
);
  localparam int CW = COORD_BITS;
  localparam int PW = $clog2(MAX_POINTS);
  localparam int NW = PW + 1;
  localparam int KW = $clog2(MAX_CLUSTERS);
  localparam int KN = KW + 1;
  localparam int SW = CW + PW;
  localparam int DW = 2 * CW + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LRD  = 4'd1;
  localparam logic [3:0] S_LWT  = 4'd2;
  localparam logic [3:0] S_LCMP = 4'd3;
  localparam logic [3:0] S_LWR  = 4'd4;
  localparam logic [3:0] S_FJ   = 4'd5;
  localparam logic [3:0] S_FBIG = 4'd6;
  localparam logic [3:0] S_FRD  = 4'd7;
  localparam logic [3:0] S_FCHK = 4'd8;
  localparam logic [3:0] S_FAPP = 4'd9;
  localparam logic [3:0] S_UJ   = 4'd10;
  localparam logic [3:0] S_UDX  = 4'd11;
  localparam logic [3:0] S_UDY  = 4'd12;
  localparam logic [3:0] S_CHK  = 4'd13;
  localparam logic [3:0] S_EMIT = 4'd14;
  localparam logic [3:0] S_RD   = 4'd15;

  logic [3:0]    state;
  logic [4:0]    num_clusters;
  logic [9:0]    max_passes;
  logic [NW-1:0] point_count;
  logic [9:0]    pass_counter;
  logic [KN-1:0] k_run;
  logic [9:0]    limit;
  logic          moved;
  logic [NW-1:0] icnt;
  logic [KN-1:0] jcnt;
  logic [KN-1:0] mcnt;
  logic [KW-1:0] big;
  logic [KW-1:0] best;
  logic [DW-1:0] bd;
  logic [DW-1:0] far;
  logic          found;
  logic [PW-1:0] pick;
  logic [CW-1:0] px, py, far_x, far_y, qx;
  logic          rd_ok;

  logic [CW-1:0] cx_arr [MAX_CLUSTERS];
  logic [CW-1:0] cy_arr [MAX_CLUSTERS];
  logic [SW-1:0] sum_x  [MAX_CLUSTERS];
  logic [SW-1:0] sum_y  [MAX_CLUSTERS];
  logic [NW-1:0] mcount [MAX_CLUSTERS];

  logic [KN-1:0] k_eff;
  logic [KW-1:0] jsel, msel;
  logic          accept;

  // point memory
  logic          xy_we, lb_we;
  logic [PW-1:0] lb_addr, rd_addr;
  logic [KW-1:0] lb_data, rd_lb;
  logic [CW-1:0] rd_x, rd_y;

  // divider
  logic          div_start, div_done;
  logic [SW-1:0] div_num, div_q;

  // shared distance unit
  logic [CW-1:0] da_x, da_y, db_x, db_y, dx, dy;
  logic [DW-1:0] sq_dist;

  assign jsel   = jcnt[KW-1:0];
  assign msel   = mcnt[KW-1:0];
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    if (num_clusters == 5'd0) k_eff = KN'(1);
    else if (32'(num_clusters) > MAX_CLUSTERS) k_eff = KN'(MAX_CLUSTERS);
    else k_eff = KN'(num_clusters);
  end

  always_comb begin
    if (state == S_FCHK) begin
      da_x = cx_arr[big];
      da_y = cy_arr[big];
      db_x = rd_x;
      db_y = rd_y;
    end else begin
      da_x = px;
      da_y = py;
      db_x = cx_arr[jsel];
      db_y = cy_arr[jsel];
    end
    dx      = (da_x > db_x) ? da_x - db_x : db_x - da_x;
    dy      = (da_y > db_y) ? da_y - db_y : db_y - da_y;
    sq_dist = DW'(dx) * DW'(dx) + DW'(dy) * DW'(dy);
  end

  always_comb begin
    xy_we   = accept && (cmd == CMD_LOAD_POINT) && (32'(point_count) < MAX_POINTS);
    lb_we   = (state == S_LWR) || (state == S_FAPP && found);
    lb_addr = (state == S_LWR) ? icnt[PW-1:0] : pick;
    lb_data = (state == S_LWR) ? best : jsel;
    if (state == S_IDLE) rd_addr = PW'(item_index);
    else rd_addr = icnt[PW-1:0];
  end

  km2d_point_mem #(
    .MAX_POINTS(MAX_POINTS), .MAX_CLUSTERS(MAX_CLUSTERS), .COORD_BITS(COORD_BITS)
  ) u_mem (
    .clk(clk), .xy_we(xy_we), .xy_addr(point_count[PW-1:0]),
    .xy_x(CW'(x_coord)), .xy_y(CW'(y_coord)),
    .lb_we(lb_we), .lb_addr(lb_addr), .lb_data(lb_data),
    .rd_addr(rd_addr), .rd_x(rd_x), .rd_y(rd_y), .rd_lb(rd_lb)
  );

  assign div_start = (state == S_UJ && jcnt != k_run && mcount[jsel] != '0) ||
                     (state == S_UDX && div_done);
  assign div_num   = (state == S_UJ) ? sum_x[jsel] : sum_y[jsel];

  km2d_divider #(.NUM_W(SW), .DEN_W(NW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_num),
    .divisor(mcount[jsel]), .done(div_done), .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      num_clusters <= 5'd2;
      max_passes   <= 10'd1002;
      point_count  <= '0;
      pass_counter <= '0;
      moved        <= 1'b0;
      k_run        <= KN'(1);
      limit        <= 10'd1;
      icnt         <= '0;
      jcnt         <= '0;
      mcnt         <= '0;
      big          <= '0;
      found        <= 1'b0;
      rd_ok        <= 1'b0;
      for (int c = 0; c < MAX_CLUSTERS; c++) begin
        sum_x[c]  <= '0;
        sum_y[c]  <= '0;
        mcount[c] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_NUM_CLUSTERS: num_clusters <= cfg_data[4:0];
          REG_MAX_PASSES:   max_passes   <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd)
              CMD_LOAD_POINT: begin
                if (32'(point_count) < MAX_POINTS) point_count <= point_count + 1'b1;
              end
              CMD_LOAD_CENTER: begin
                if (32'(item_index) < MAX_CLUSTERS) begin
                  cx_arr[KW'(item_index)] <= CW'(x_coord);
                  cy_arr[KW'(item_index)] <= CW'(y_coord);
                end
              end
              CMD_RUN: begin
                k_run        <= k_eff;
                limit        <= (max_passes == 10'd0) ? 10'd1 : max_passes;
                pass_counter <= '0;
                moved        <= 1'b0;
                icnt         <= '0;
                for (int c = 0; c < MAX_CLUSTERS; c++) begin
                  sum_x[c]  <= '0;
                  sum_y[c]  <= '0;
                  mcount[c] <= '0;
                end
                state <= S_LRD;
              end
              CMD_READ: begin
                rd_ok <= (32'(item_index) < MAX_POINTS);
                state <= S_RD;
              end
              default: ;
            endcase
          end
        end
        S_LRD: begin
          jcnt <= '0;
          if (icnt == point_count) state <= S_FJ;
          else state <= S_LWT;
        end
        S_LWT: begin
          px    <= rd_x;
          py    <= rd_y;
          state <= S_LCMP;
        end
        S_LCMP: begin
          // strict compare keeps the lowest index on a tie
          if (jcnt == '0 || sq_dist < bd) begin
            bd   <= sq_dist;
            best <= jsel;
          end
          jcnt <= jcnt + 1'b1;
          if (jcnt == k_run - 1'b1) state <= S_LWR;
        end
        S_LWR: begin
          mcount[best] <= mcount[best] + 1'b1;
          sum_x[best]  <= sum_x[best] + SW'(px);
          sum_y[best]  <= sum_y[best] + SW'(py);
          icnt         <= icnt + 1'b1;
          state        <= S_LRD;
        end
        S_FJ: begin
          if (jcnt == k_run) begin
            jcnt  <= '0;
            state <= S_UJ;
          end else if (mcount[jsel] != '0) begin
            jcnt <= jcnt + 1'b1;
          end else begin
            big   <= '0;
            mcnt  <= KN'(1);
            state <= S_FBIG;
          end
        end
        S_FBIG: begin
          if (mcnt < k_run) begin
            if (mcount[msel] > mcount[big]) big <= msel;
            mcnt <= mcnt + 1'b1;
          end else if (mcount[big] == '0) begin
            jcnt  <= jcnt + 1'b1;
            state <= S_FJ;
          end else begin
            icnt  <= '0;
            found <= 1'b0;
            state <= S_FRD;
          end
        end
        S_FRD: begin
          if (icnt == point_count) state <= S_FAPP;
          else state <= S_FCHK;
        end
        S_FCHK: begin
          if (rd_lb == big && (!found || sq_dist > far)) begin
            far   <= sq_dist;
            pick  <= icnt[PW-1:0];
            far_x <= rd_x;
            far_y <= rd_y;
            found <= 1'b1;
          end
          icnt  <= icnt + 1'b1;
          state <= S_FRD;
        end
        S_FAPP: begin
          if (found) begin
            mcount[jsel] <= mcount[jsel] + 1'b1;
            sum_x[jsel]  <= sum_x[jsel] + SW'(far_x);
            sum_y[jsel]  <= sum_y[jsel] + SW'(far_y);
            mcount[big]  <= mcount[big] - 1'b1;
            sum_x[big]   <= sum_x[big] - SW'(far_x);
            sum_y[big]   <= sum_y[big] - SW'(far_y);
          end
          jcnt  <= jcnt + 1'b1;
          state <= S_FJ;
        end
        S_UJ: begin
          if (jcnt == k_run) state <= S_CHK;
          else if (mcount[jsel] == '0) jcnt <= jcnt + 1'b1;
          else state <= S_UDX;
        end
        S_UDX: begin
          if (div_done) begin
            qx    <= CW'(div_q);
            state <= S_UDY;
          end
        end
        S_UDY: begin
          if (div_done) begin
            if (qx != cx_arr[jsel] || CW'(div_q) != cy_arr[jsel]) moved <= 1'b1;
            cx_arr[jsel] <= qx;
            cy_arr[jsel] <= CW'(div_q);
            jcnt         <= jcnt + 1'b1;
            state        <= S_UJ;
          end
        end
        S_CHK: begin
          pass_counter <= pass_counter + 1'b1;
          jcnt         <= '0;
          if (moved && (pass_counter + 1'b1) < limit) begin
            moved <= 1'b0;
            icnt  <= '0;
            for (int c = 0; c < MAX_CLUSTERS; c++) begin
              sum_x[c]  <= '0;
              sum_y[c]  <= '0;
              mcount[c] <= '0;
            end
            state <= S_LRD;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          jcnt <= jcnt + 1'b1;
          if (jcnt == k_run - 1'b1) state <= S_IDLE;
        end
        S_RD: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    done          = (state == S_EMIT) || (state == S_RD);
    passes_done   = pass_counter;
    if (state == S_EMIT) begin
      cluster_index = LABEL_W'(jcnt);
      center_x      = FIELD_W'(cx_arr[jsel]);
      center_y      = FIELD_W'(cy_arr[jsel]);
      label         = '0;
      converged     = !moved;
      last          = (jcnt == k_run - 1'b1);
    end else begin
      cluster_index = '0;
      center_x      = '0;
      center_y      = '0;
      label         = rd_ok ? LABEL_W'(rd_lb) : '0;
      converged     = 1'b0;
      last          = (state == S_RD);
    end
  end
endmodule

@@ sv/km2d_checker.sv @@
// km2d_checker: port-level assertions on the k-means block, bound to the top
// uses km2d_pkg and kmeans_2d_cluster_macros.svh
`timescale 1ns / 1ps
`include "kmeans_2d_cluster_macros.svh"
module km2d_checker import km2d_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] cmd,
  input logic       done,
  input logic       last
);
  logic take_read, take_load;
  assign take_read = start && !busy && (cmd == CMD_READ);
  assign take_load = start && !busy && (cmd == CMD_LOAD_POINT || cmd == CMD_LOAD_CENTER);

  // a label read answers with a single final beat next cycle
  `KM_ASSERT_NEXT(a_read_answers, clk, rst, take_read, done && last)
  // loads produce no beat
  `KM_ASSERT_NEXT(a_load_silent, clk, rst, take_load, !done)
  // the block is free again right after the final beat
  `KM_ASSERT_NEXT(a_idle_after_last, clk, rst, done && last, !busy)
  // run results come back to back
  `KM_ASSERT_NEXT(a_emit_burst, clk, rst, done && !last, done)
  // results only appear while a command is in flight
  `KM_ASSERT_NOW(a_done_busy, clk, rst, done, busy)
endmodule

bind kmeans_2d_cluster km2d_checker u_km2d_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
  .done(done), .last(last)
);
